>>> design/latency_histogram_stats_core_assert.svh
// Assertion macros for the port-level checker of the latency histogram core.
`ifndef LATENCY_HISTOGRAM_STATS_CORE_ASSERT_SVH
`define LATENCY_HISTOGRAM_STATS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lhs_pkg.sv
// Package with the shared types, constants and helpers of the latency histogram core.
`default_nettype none

package lhs_pkg;

  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 48;
  localparam int FIELD_W   = 32;
  localparam int BKT_W     = 3;
  localparam int NUM_BKT   = 6;
  localparam int NUM_BOUND = 5;

  typedef logic [BKT_W-1:0] bkt_t;

  localparam bkt_t BKT_CLEAR = 3'd0;
  localparam bkt_t BKT_OVER  = 3'd5;

  // Upper bucket bounds in whole milliseconds.
  localparam logic [5:0] BOUND_MS [NUM_BOUND] = '{6'd1, 6'd2, 6'd5, 6'd10, 6'd50};

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_CLEAR  = 1'b1
  } act_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } lhs_cmd_t;

  typedef struct packed {
    logic div_done;
  } lhs_sts_t;

  function automatic logic [SAMPLE_W-1:0] bound_fixed(input int idx, input int frac);
    logic [SAMPLE_W-1:0] b;
    b = SAMPLE_W'(BOUND_MS[idx]);
    bound_fixed = b << frac;
  endfunction

endpackage

`default_nettype wire

>>> design/lhs_chan_if.sv
// Channel interfaces for the sample input and the statistics output.
`default_nettype none

interface lhs_in_if;
  import lhs_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] sample_latency;

  modport source (output valid, output action, output sample_latency, input ready);
  modport sink   (input valid, input action, input sample_latency, output ready);
endinterface

interface lhs_out_if;
  import lhs_pkg::*;

  logic               valid;
  logic               ready;
  logic [BKT_W-1:0]   bucket_index;
  logic [FIELD_W-1:0] total_calls;
  logic [SUM_W-1:0]   latency_total;
  logic [FIELD_W-1:0] mean_latency;
  logic [FIELD_W-1:0] peak_latency;
  logic [FIELD_W-1:0] count_under_1ms;
  logic [FIELD_W-1:0] count_1_to_2ms;
  logic [FIELD_W-1:0] count_2_to_5ms;
  logic [FIELD_W-1:0] count_5_to_10ms;
  logic [FIELD_W-1:0] count_10_to_50ms;
  logic [FIELD_W-1:0] count_over_50ms;

  modport source (
    output valid, output bucket_index, output total_calls, output latency_total,
    output mean_latency, output peak_latency, output count_under_1ms,
    output count_1_to_2ms, output count_2_to_5ms, output count_5_to_10ms,
    output count_10_to_50ms, output count_over_50ms, input ready
  );
  modport sink (
    input valid, input bucket_index, input total_calls, input latency_total,
    input mean_latency, input peak_latency, input count_under_1ms,
    input count_1_to_2ms, input count_2_to_5ms, input count_5_to_10ms,
    input count_10_to_50ms, input count_over_50ms, output ready
  );
endinterface

`default_nettype wire

>>> design/lhs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module lhs_div #(
  parameter int DIVD_W = 48,
  parameter int DIVS_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic              last_step
);

  localparam int CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVD_W - 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;

  assign trial     = {rem_r, quo_r[DIVD_W-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign fits      = trial >= {1'b0, dvs_r};
  assign last_step = busy_r && (cnt_r == LAST_CNT);
  assign quotient  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The dividend shifts out at the top while quotient bits shift in below.
      rem_nxt = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

>>> design/lhs_datapath.sv
// Datapath: statistics registers, bucket selection, mean divider and result register.
`default_nettype none

module lhs_datapath #(
  parameter int COUNT_WIDTH   = lhs_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = lhs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lhs_pkg::lhs_cmd_t             cmd,
  output lhs_pkg::lhs_sts_t             sts,
  input  logic                          in_action,
  input  logic [lhs_pkg::SAMPLE_W-1:0]  in_sample,
  output logic [lhs_pkg::BKT_W-1:0]     out_bucket_index,
  output logic [lhs_pkg::FIELD_W-1:0]   out_total_calls,
  output logic [lhs_pkg::SUM_W-1:0]     out_latency_total,
  output logic [lhs_pkg::FIELD_W-1:0]   out_mean_latency,
  output logic [lhs_pkg::FIELD_W-1:0]   out_peak_latency,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_under_1ms,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_1_to_2ms,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_2_to_5ms,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_5_to_10ms,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_10_to_50ms,
  output logic [lhs_pkg::FIELD_W-1:0]   out_count_over_50ms
);
  import lhs_pkg::*;

  act_t                   act_r;
  logic [SAMPLE_W-1:0]    smp_r;

  logic [COUNT_WIDTH-1:0] bcnt_r [NUM_BKT];
  logic [COUNT_WIDTH-1:0] bcnt_nxt [NUM_BKT];
  logic [COUNT_WIDTH-1:0] calls_r, calls_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]    peak_r, peak_nxt;
  bkt_t                   bkt_r, bkt_nxt;

  bkt_t                   bkt_pick;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_add;
  logic [COUNT_WIDTH-1:0] calls_inc;
  logic [SUM_W-1:0]       quo;
  logic [FIELD_W-1:0]     mean_val;

  bkt_t                   obkt_r;
  logic [FIELD_W-1:0]     ocalls_r;
  logic [SUM_W-1:0]       osum_r;
  logic [FIELD_W-1:0]     omean_r;
  logic [FIELD_W-1:0]     opeak_r;
  logic [FIELD_W-1:0]     ocnt_r [NUM_BKT];

  // A sample equal to a bound belongs to the lower bucket.
  always_comb begin
    bkt_pick = BKT_OVER;
    for (int i = NUM_BOUND - 1; i >= 0; i--) begin
      if (smp_r <= bound_fixed(i, FRACTION_BITS)) begin
        bkt_pick = BKT_W'(i);
      end
    end
  end

  assign sum_ext   = {1'b0, sum_r} + (SUM_W + 1)'(smp_r);
  assign sum_add   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign calls_inc = (&calls_r) ? calls_r : calls_r + 1'b1;

  always_comb begin
    calls_nxt = calls_r;
    sum_nxt   = sum_r;
    peak_nxt  = peak_r;
    bkt_nxt   = bkt_r;
    for (int i = 0; i < NUM_BKT; i++) begin
      bcnt_nxt[i] = bcnt_r[i];
    end
    if (cmd.update) begin
      if (act_r == ACT_CLEAR) begin
        calls_nxt = '0;
        sum_nxt   = '0;
        peak_nxt  = '0;
        bkt_nxt   = BKT_CLEAR;
        for (int i = 0; i < NUM_BKT; i++) begin
          bcnt_nxt[i] = '0;
        end
      end else begin
        calls_nxt = calls_inc;
        sum_nxt   = sum_add;
        peak_nxt  = (smp_r > peak_r) ? smp_r : peak_r;
        bkt_nxt   = bkt_pick;
        for (int i = 0; i < NUM_BKT; i++) begin
          if (bkt_pick == BKT_W'(i) && !(&bcnt_r[i])) begin
            bcnt_nxt[i] = bcnt_r[i] + 1'b1;
          end
        end
      end
    end
  end

  // The divider is loaded with the statistics as they stand after the update.
  lhs_div #(
    .DIVD_W (SUM_W),
    .DIVS_W (COUNT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (sum_nxt),
    .divisor   (calls_nxt),
    .quotient  (quo),
    .last_step (sts.div_done)
  );

  always_comb begin
    if (calls_r == '0) begin
      mean_val = '0;
    end else if (|quo[SUM_W-1:FIELD_W]) begin
      mean_val = {FIELD_W{1'b1}};
    end else begin
      mean_val = quo[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calls_r <= '0;
      sum_r   <= '0;
      peak_r  <= '0;
      bkt_r   <= BKT_CLEAR;
      for (int i = 0; i < NUM_BKT; i++) begin
        bcnt_r[i] <= '0;
      end
    end else begin
      calls_r <= calls_nxt;
      sum_r   <= sum_nxt;
      peak_r  <= peak_nxt;
      bkt_r   <= bkt_nxt;
      for (int i = 0; i < NUM_BKT; i++) begin
        bcnt_r[i] <= bcnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= act_t'(in_action);
      smp_r <= in_sample;
    end
    if (cmd.load_out) begin
      obkt_r   <= bkt_r;
      ocalls_r <= FIELD_W'(calls_r);
      osum_r   <= sum_r;
      omean_r  <= mean_val;
      opeak_r  <= peak_r;
      for (int i = 0; i < NUM_BKT; i++) begin
        ocnt_r[i] <= FIELD_W'(bcnt_r[i]);
      end
    end
  end

  assign out_bucket_index     = obkt_r;
  assign out_total_calls      = ocalls_r;
  assign out_latency_total    = osum_r;
  assign out_mean_latency     = omean_r;
  assign out_peak_latency     = opeak_r;
  assign out_count_under_1ms  = ocnt_r[0];
  assign out_count_1_to_2ms   = ocnt_r[1];
  assign out_count_2_to_5ms   = ocnt_r[2];
  assign out_count_5_to_10ms  = ocnt_r[3];
  assign out_count_10_to_50ms = ocnt_r[4];
  assign out_count_over_50ms  = ocnt_r[5];

endmodule

`default_nettype wire

>>> design/lhs_ctrl.sv
// Controller state machine that sequences capture, update, divide and result hand-off.
`default_nettype none

module lhs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lhs_pkg::lhs_sts_t sts,
  output lhs_pkg::lhs_cmd_t cmd
);
  import lhs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update    = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // The result register takes a new beat once the previous one has left.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/latency_histogram_stats_core.sv
// Top level of the latency histogram core with running sum, peak and mean.
//
// Usage: one beat on in_ch carries an action and a latency sample (ms, fixed
// point). A record action sorts the sample into one of six buckets bounded at
// 1, 2, 5, 10 and 50 ms and updates the saturating counters, the 48-bit sum
// and the peak; a clear action zeroes every statistic. Every input beat yields
// exactly one beat on out_ch with the statistics and the truncated mean.
// The mean is the 48-bit sum divided by the call count, one bit per cycle;
// no new input beat is taken until that divide is done and the result loaded.
// in_ch.ready is high only while no beat is in work. The result sits in an
// output register, so a stalled receiver delays the hand-off of the next
// result; the following input beat is still taken and worked on meanwhile.
// Reset (rst_n low, synchronous) zeroes all statistics and drops out_ch.valid.
`default_nettype none

module latency_histogram_stats_core #(
  parameter int COUNT_WIDTH   = lhs_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = lhs_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lhs_in_if.sink     in_ch,
  lhs_out_if.source  out_ch
);
  import lhs_pkg::*;

  lhs_cmd_t cmd;
  lhs_sts_t sts;

  lhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lhs_datapath #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_ch.action),
    .in_sample            (in_ch.sample_latency),
    .out_bucket_index     (out_ch.bucket_index),
    .out_total_calls      (out_ch.total_calls),
    .out_latency_total    (out_ch.latency_total),
    .out_mean_latency     (out_ch.mean_latency),
    .out_peak_latency     (out_ch.peak_latency),
    .out_count_under_1ms  (out_ch.count_under_1ms),
    .out_count_1_to_2ms   (out_ch.count_1_to_2ms),
    .out_count_2_to_5ms   (out_ch.count_2_to_5ms),
    .out_count_5_to_10ms  (out_ch.count_5_to_10ms),
    .out_count_10_to_50ms (out_ch.count_10_to_50ms),
    .out_count_over_50ms  (out_ch.count_over_50ms)
  );

endmodule

`default_nettype wire

>>> design/lhs_chk.sv
// Port-level checker for the latency histogram core and its bind statement.
`default_nettype none
`include "latency_histogram_stats_core_assert.svh"

module lhs_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [lhs_pkg::BKT_W-1:0]     out_bucket_index,
  input wire logic [lhs_pkg::FIELD_W-1:0]   out_total_calls,
  input wire logic [lhs_pkg::SUM_W-1:0]     out_latency_total,
  input wire logic [lhs_pkg::FIELD_W-1:0]   out_mean_latency,
  input wire logic [lhs_pkg::FIELD_W-1:0]   out_peak_latency
);
  import lhs_pkg::*;

  // Only one beat is in work at a time.
  `LHS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready not dropped after accept")

  `LHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  `LHS_ASSERT_NOW(a_bucket_range, out_valid, out_bucket_index <= BKT_OVER, "bucket index out of range")

  // With no calls and a zero peak, no sample has been recorded, so sum and mean are zero.
  `LHS_ASSERT_NOW(a_empty_stats, out_valid && out_total_calls == '0 && out_peak_latency == '0, out_latency_total == '0 && out_mean_latency == '0, "nonzero sum or mean with no samples")

endmodule

bind latency_histogram_stats_core lhs_chk u_lhs_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_bucket_index  (out_ch.bucket_index),
  .out_total_calls   (out_ch.total_calls),
  .out_latency_total (out_ch.latency_total),
  .out_mean_latency  (out_ch.mean_latency),
  .out_peak_latency  (out_ch.peak_latency)
);

`default_nettype wire

>>> test/lhs_stats_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the latency statistics from input beats and compares every result beat.
module lhs_stats_checker #(
  parameter int COUNT_WIDTH   = lhs_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = lhs_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lhs_in_if    in_ch,
  lhs_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);
  import lhs_pkg::*;

  typedef struct packed {
    bkt_t                             bucket;
    logic [FIELD_W-1:0]               calls;
    logic [SUM_W-1:0]                 total;
    logic [FIELD_W-1:0]               mean;
    logic [FIELD_W-1:0]               peak;
    logic [NUM_BKT-1:0][FIELD_W-1:0]  hist;
  } stats_t;

  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] SUM_MAX   = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] MEAN_MAX  = 64'hFFFF_FFFF;
  localparam logic [63:0] LIMIT_MS [NUM_BOUND] = '{64'd1, 64'd2, 64'd5, 64'd10, 64'd50};
  localparam string HIST_NAME [NUM_BKT] = '{"count_under_1ms", "count_1_to_2ms",
    "count_2_to_5ms", "count_5_to_10ms", "count_10_to_50ms", "count_over_50ms"};

  logic [63:0] hist_cnt [NUM_BKT];
  logic [63:0] lat_sum;
  logic [63:0] call_cnt;
  logic [63:0] peak_seen;
  stats_t      pending_stats [$];
  int          printed;

  function automatic logic [63:0] bump_count(input logic [63:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 64'd1;
  endfunction

  // Applies one input beat to the model state and returns the statistics it reports.
  function automatic stats_t fold_sample(input logic act, input logic [SAMPLE_W-1:0] s);
    stats_t      r;
    bkt_t        b;
    logic [63:0] q;
    r = '0;
    b = BKT_CLEAR;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < NUM_BKT; i++) hist_cnt[i] = '0;
      lat_sum   = '0;
      call_cnt  = '0;
      peak_seen = '0;
    end else begin
      // A sample equal to a bound stays in the lower bucket.
      b = BKT_OVER;
      for (int i = NUM_BOUND - 1; i >= 0; i--)
        if (64'(s) <= (LIMIT_MS[i] << FRACTION_BITS)) b = bkt_t'(i);
      hist_cnt[b] = bump_count(hist_cnt[b]);
      lat_sum     = (lat_sum > SUM_MAX - 64'(s)) ? SUM_MAX : lat_sum + 64'(s);
      call_cnt    = bump_count(call_cnt);
      if (peak_seen < 64'(s)) peak_seen = 64'(s);
    end
    q = '0;
    if (call_cnt != 0) begin
      q = lat_sum / call_cnt;
      if (q > MEAN_MAX) q = MEAN_MAX;
    end
    r.bucket = b;
    r.calls  = call_cnt[FIELD_W-1:0];
    r.total  = lat_sum[SUM_W-1:0];
    r.mean   = q[FIELD_W-1:0];
    r.peak   = peak_seen[FIELD_W-1:0];
    for (int i = 0; i < NUM_BKT; i++) r.hist[i] = hist_cnt[i][FIELD_W-1:0];
    return r;
  endfunction

  // Appends the expected statistics of one input beat behind those already waiting.
  task automatic stash_expected(input stats_t s);
    pending_stats = {pending_stats, s};
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (printed < 40) begin
      printed++;
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", what, got, want));
  endtask

  always @(posedge clk) begin
    stats_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BKT; i++) hist_cnt[i] = '0;
      lat_sum   = '0;
      call_cnt  = '0;
      peak_seen = '0;
      pending_stats.delete();
      mismatches = 0;
      printed    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        stash_expected(fold_sample(in_ch.action, in_ch.sample_latency));
      if (out_ch.valid && out_ch.ready) begin
        if (pending_stats.size() == 0) begin
          report("result beat with no input beat waiting for it");
        end else begin
          want = pending_stats.pop_front();
          check_field("bucket_index", out_ch.bucket_index, want.bucket);
          check_field("total_calls", out_ch.total_calls, want.calls);
          check_field("latency_total", out_ch.latency_total, want.total);
          check_field("mean_latency", out_ch.mean_latency, want.mean);
          check_field("peak_latency", out_ch.peak_latency, want.peak);
          check_field(HIST_NAME[0], out_ch.count_under_1ms, want.hist[0]);
          check_field(HIST_NAME[1], out_ch.count_1_to_2ms, want.hist[1]);
          check_field(HIST_NAME[2], out_ch.count_2_to_5ms, want.hist[2]);
          check_field(HIST_NAME[3], out_ch.count_5_to_10ms, want.hist[3]);
          check_field(HIST_NAME[4], out_ch.count_10_to_50ms, want.hist[4]);
          check_field(HIST_NAME[5], out_ch.count_over_50ms, want.hist[5]);
        end
      end
    end
    outstanding = pending_stats.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the latency histogram core: stimulus, flow control and verdict.
module tb;
  import lhs_pkg::*;

  localparam int FRAC         = FRACTION_BITS_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;

  // Upper edge of each bucket in fixed point; the last bucket runs to the top of the field.
  localparam logic [SAMPLE_W-1:0] BKT_HI [NUM_BKT] = '{
    32'd1 << FRAC, 32'd2 << FRAC, 32'd5 << FRAC, 32'd10 << FRAC, 32'd50 << FRAC,
    32'hFFFF_FFFF
  };

  logic clk;
  logic rst_n;
  int   cycles;
  int   mismatches;
  int   outstanding;

  lhs_in_if  in_ch ();
  lhs_out_if out_ch ();

  latency_histogram_stats_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lhs_stats_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(5, 1);
    return $urandom_range(90, 10);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    int b;
    sel = $urandom_range(99);
    b   = $urandom_range(NUM_BKT - 1);
    if (sel < 20) return $urandom;
    if (sel < 35) return BKT_HI[$urandom_range(NUM_BOUND - 1)] + $urandom_range(2) - 1;
    if (b == 0) return $urandom_range(BKT_HI[0], 0);
    return $urandom_range(BKT_HI[b], BKT_HI[b-1] + 1);
  endfunction

  task automatic send_beat(input act_t act, input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.sample_latency <= sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Receiver: stretches of readiness, some of them long, between stalls of varied length.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      n = ($urandom_range(9) == 0) ? $urandom_range(300, 80) : $urandom_range(30, 1);
      out_ch.ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = ($urandom_range(9) == 0) ? $urandom_range(150, 20) : $urandom_range(4, 1);
      out_ch.ready <= 1'b0;
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    cycles               = 0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_RECORD;
    in_ch.sample_latency = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each bucket edge exactly and one step above it, extremes, clears.
    send_beat(ACT_RECORD, 32'd0);
    for (int i = 0; i < NUM_BOUND; i++) begin
      send_beat(ACT_RECORD, BKT_HI[i]);
      send_beat(ACT_RECORD, BKT_HI[i] + 32'd1);
    end
    send_beat(ACT_RECORD, 32'hFFFF_FFFF);
    send_beat(ACT_RECORD, 32'hFFFF_FFFF);
    send_beat(ACT_CLEAR, 32'hFFFF_FFFF);
    send_beat(ACT_CLEAR, 32'd0);
    send_beat(ACT_RECORD, 32'd1);
    send_beat(ACT_RECORD, 32'hAAAA_AAAA);
    send_beat(ACT_RECORD, 32'h5555_5555);
    send_beat(ACT_CLEAR, 32'h1234_5678);
    send_beat(ACT_RECORD, 32'hFFFF_FFFF);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(99) < 4) send_beat(ACT_CLEAR, $urandom);
      else send_beat(ACT_RECORD, pick_sample());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lhs_pkg.sv
design/lhs_chan_if.sv
design/lhs_div.sv
design/lhs_datapath.sv
design/lhs_ctrl.sv
design/latency_histogram_stats_core.sv
design/lhs_chk.sv
test/lhs_stats_checker.sv
test/tb.sv
